>>> hw/rtl/irts_pkg.sv
`timescale 1ns / 1ps

package irts_pkg;

   localparam int TC_BITS = 4;
   localparam int MAX_THREADS = 8;
   localparam int DIM_BITS_DEFAULT = 16;

   localparam logic [TC_BITS-1:0] TC_LIMIT =
      TC_BITS'((MAX_THREADS < (2 ** TC_BITS) - 1) ? MAX_THREADS : (2 ** TC_BITS) - 1);

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

endpackage

>>> hw/rtl/irts_front.sv
`timescale 1ns / 1ps

module irts_front #(
   parameter int DIM_BITS = irts_pkg::DIM_BITS_DEFAULT,
   parameter type task_type = logic
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [irts_pkg::TC_BITS-1:0] thread_count,
   input  logic [DIM_BITS-1:0]          image_height,
   input  logic [DIM_BITS-1:0]          image_width,
   output logic                         push,
   output task_type                     push_data,
   input  logic                         full
);
   import irts_pkg::*;

   localparam int CNT_BITS = (DIM_BITS > 1) ? $clog2(DIM_BITS) : 1;

   front_state_type state_ff, state_in;
   logic [TC_BITS-1:0]  n_ff, n_in;
   logic [DIM_BITS-1:0] h_ff, h_in, w_ff, w_in;
   logic [DIM_BITS-1:0] qh_ff, qh_in, qw_ff, qw_in;
   logic [TC_BITS-1:0]  rh_ff, rh_in, rw_ff, rw_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   logic [TC_BITS-1:0]  n_sat;
   logic [TC_BITS:0]    th, tw;
   logic                geh, gew;
   logic                accept, split_rows, count_zero;
   logic [DIM_BITS-1:0] quot;
   logic [TC_BITS-1:0]  rem, band_count;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      n_sat = thread_count;
      if (thread_count == '0) begin
         n_sat = TC_BITS'(1);
      end else if (thread_count > TC_LIMIT) begin
         n_sat = TC_LIMIT;
      end
   end

   // One quotient bit per cycle for both dimensions.
   assign th  = {rh_ff, qh_ff[DIM_BITS-1]};
   assign tw  = {rw_ff, qw_ff[DIM_BITS-1]};
   assign geh = th >= {1'b0, n_ff};
   assign gew = tw >= {1'b0, n_ff};

   always_comb begin
      if (rh_ff == '0) begin
         split_rows = 1'b1;
      end else if (rw_ff == '0) begin
         split_rows = 1'b0;
      end else begin
         split_rows = h_ff > w_ff;
      end
   end

   assign quot       = split_rows ? qh_ff : qw_ff;
   assign rem        = split_rows ? rh_ff : rw_ff;
   assign band_count = (quot == '0) ? rem : n_ff;
   assign count_zero = band_count == '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE: begin
            if (accept) begin
               state_in = FRONT_DIVIDE;
            end
         end
         FRONT_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = FRONT_PUSH;
            end
         end
         FRONT_PUSH: begin
            if (count_zero || !full) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      push       = 1'b0;
      case (state_ff)
         FRONT_IDLE:   req_tready = 1'b1;
         FRONT_DIVIDE: req_tready = 1'b0;
         FRONT_PUSH:   push = !count_zero && !full;
         default:      req_tready = 1'b0;
      endcase
   end

   always_comb begin
      push_data.split_rows   = split_rows;
      push_data.quotient     = quot;
      push_data.remainder    = rem;
      push_data.band_count   = band_count;
      push_data.image_height = h_ff;
      push_data.image_width  = w_ff;
   end

   always_comb begin
      n_in   = n_ff;
      h_in   = h_ff;
      w_in   = w_ff;
      qh_in  = qh_ff;
      qw_in  = qw_ff;
      rh_in  = rh_ff;
      rw_in  = rw_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         n_in   = n_sat;
         h_in   = image_height;
         w_in   = image_width;
         qh_in  = image_height;
         qw_in  = image_width;
         rh_in  = '0;
         rw_in  = '0;
         cnt_in = CNT_BITS'(DIM_BITS - 1);
      end else if (state_ff == FRONT_DIVIDE) begin
         qh_in  = {qh_ff[DIM_BITS-2:0], geh};
         qw_in  = {qw_ff[DIM_BITS-2:0], gew};
         rh_in  = geh ? TC_BITS'(th - {1'b0, n_ff}) : th[TC_BITS-1:0];
         rw_in  = gew ? TC_BITS'(tw - {1'b0, n_ff}) : tw[TC_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff   <= n_in;
      h_ff   <= h_in;
      w_ff   <= w_in;
      qh_ff  <= qh_in;
      qw_ff  <= qw_in;
      rh_ff  <= rh_in;
      rw_ff  <= rw_in;
      cnt_ff <= cnt_in;
   end

endmodule

>>> hw/rtl/irts_queue.sv
`timescale 1ns / 1ps

module irts_queue #(
   parameter type task_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_data,
   output logic     full,
   input  logic     pop,
   output task_type pop_data,
   output logic     empty
);

   task_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full     = fill_ff == 2'd2;
   assign empty    = fill_ff == 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/irts_back.sv
`timescale 1ns / 1ps

module irts_back #(
   parameter int DIM_BITS = irts_pkg::DIM_BITS_DEFAULT,
   parameter type task_type = logic
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  task_type            pop_data,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DIM_BITS-1:0] top_row,
   output logic [DIM_BITS-1:0] left_column,
   output logic [DIM_BITS-1:0] row_count,
   output logic [DIM_BITS-1:0] column_count,
   output logic                last_region
);
   import irts_pkg::*;

   back_state_type      state_ff, state_in;
   task_type            task_ff, task_in;
   logic [TC_BITS-1:0]  idx_ff, idx_in;
   logic [DIM_BITS-1:0] pos_ff, pos_in;
   logic                valid_ff, valid_in;
   logic [DIM_BITS-1:0] top_ff, top_in, left_ff, left_in;
   logic [DIM_BITS-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic                last_ff, last_in;

   logic                out_free, emit, last_band;
   logic [DIM_BITS-1:0] part;

   assign out_free  = !valid_ff || rsp_tready;
   assign last_band = idx_ff == task_ff.band_count - TC_BITS'(1);
   assign part      = task_ff.quotient +
                      DIM_BITS'(idx_ff < task_ff.remainder);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!empty) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_free && last_band) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop  = 1'b0;
      emit = 1'b0;
      case (state_ff)
         BACK_IDLE: pop = !empty;
         BACK_EMIT: emit = out_free;
         default:   pop = 1'b0;
      endcase
   end

   always_comb begin
      task_in  = task_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      valid_in = rsp_tready ? 1'b0 : valid_ff;
      top_in   = top_ff;
      left_in  = left_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      last_in  = last_ff;
      if (pop) begin
         task_in = pop_data;
         idx_in  = '0;
         pos_in  = '0;
      end
      if (emit) begin
         idx_in   = idx_ff + TC_BITS'(1);
         pos_in   = pos_ff + part;
         valid_in = 1'b1;
         last_in  = last_band;
         if (task_ff.split_rows) begin
            top_in  = pos_ff;
            left_in = '0;
            rows_in = part;
            cols_in = task_ff.image_width;
         end else begin
            top_in  = '0;
            left_in = pos_ff;
            rows_in = task_ff.image_height;
            cols_in = part;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      task_ff <= task_in;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      top_ff  <= top_in;
      left_ff <= left_in;
      rows_ff <= rows_in;
      cols_ff <= cols_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign top_row      = top_ff;
   assign left_column  = left_ff;
   assign row_count    = rows_ff;
   assign column_count = cols_ff;
   assign last_region  = last_ff;

endmodule

>>> hw/rtl/image_region_thread_splitter.sv
`timescale 1ns / 1ps

// Splits an image of the given height and width into up to thread_count bands along one
// dimension (a zero thread_count counts as one, and at most 8 bands are made) and returns
// one rectangle transaction per nonempty band, the final one with tlast set. The front end
// uses a radix-2 divider that forms one quotient bit per cycle for height and width
// together; after it loads each task from the queue, the back end returns one rectangle
// per cycle while rsp_tready does not stall it. A two-entry queue between them lets the
// next request divide while the previous one is still being returned.

module image_region_thread_splitter #(
   parameter int DIM_BITS = irts_pkg::DIM_BITS_DEFAULT
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 req_tvalid,
   output logic                                                 req_tready,
   // thread_count, image_height, image_width, zero fill
   input  logic [((irts_pkg::TC_BITS + 2 * DIM_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                                 rsp_tvalid,
   input  logic                                                 rsp_tready,
   // top_row, left_column, row_count, column_count, zero fill
   output logic [((4 * DIM_BITS + 7) / 8) * 8 - 1:0]            rsp_tdata,
   output logic                                                 rsp_tlast
);
   import irts_pkg::*;

   localparam int RSP_BITS = ((4 * DIM_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic                split_rows;
      logic [DIM_BITS-1:0] quotient;
      logic [TC_BITS-1:0]  remainder;
      logic [TC_BITS-1:0]  band_count;
      logic [DIM_BITS-1:0] image_height;
      logic [DIM_BITS-1:0] image_width;
   } task_type;

   logic     push, full, pop, empty;
   task_type push_data, pop_data;
   logic [DIM_BITS-1:0] top_row, left_column, row_count, column_count;

   irts_front #(
      .DIM_BITS  (DIM_BITS),
      .task_type (task_type)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .thread_count (req_tdata[TC_BITS-1:0]),
      .image_height (req_tdata[TC_BITS+DIM_BITS-1:TC_BITS]),
      .image_width  (req_tdata[TC_BITS+2*DIM_BITS-1:TC_BITS+DIM_BITS]),
      .push         (push),
      .push_data    (push_data),
      .full         (full)
   );

   irts_queue #(
      .task_type (task_type)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   irts_back #(
      .DIM_BITS  (DIM_BITS),
      .task_type (task_type)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .top_row      (top_row),
      .left_column  (left_column),
      .row_count    (row_count),
      .column_count (column_count),
      .last_region  (rsp_tlast)
   );

   assign rsp_tdata = RSP_BITS'({column_count, row_count, left_column, top_row});

endmodule

>>> hw/rtl/irts_checker.sv
`timescale 1ns / 1ps

module irts_checker #(
   parameter int DIM_BITS = irts_pkg::DIM_BITS_DEFAULT
) (
   input logic                                                 clock,
   input logic                                                 reset,
   input logic                                                 req_tvalid,
   input logic                                                 req_tready,
   input logic [((irts_pkg::TC_BITS + 2 * DIM_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input logic                                                 rsp_tvalid,
   input logic                                                 rsp_tready,
   input logic [((4 * DIM_BITS + 7) / 8) * 8 - 1:0]            rsp_tdata,
   input logic                                                 rsp_tlast
);

   // A pending result must hold until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("pending result changed before it was taken");

   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty and ready after reset");

   // Every region starts at the image edge along the dimension that is not split.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[DIM_BITS-1:0] == '0) ||
                     (rsp_tdata[2*DIM_BITS-1:DIM_BITS] == '0))
      else $error("region offset in both dimensions");

   // No further request is taken while the divider is busy after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("request taken while the divider is busy");

endmodule

bind image_region_thread_splitter irts_checker #(.DIM_BITS(DIM_BITS)) u_checker (.*);
